// File: hw/rtl/lbc_pkg.sv
// shared types, constants and round functions for the lblock cipher
package lbc_pkg;

    // field and state widths
    localparam int HALF_W         = 32;
    localparam int BLOCK_W        = 64;
    localparam int KEY_W          = 80;
    localparam int KEY_HIGH_W     = 16;
    localparam int RND_W          = 6;
    localparam int KIDX_W         = 5;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 64;
    localparam int MAX_ROUNDS_DEF = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUND_COUNT = 2'd2;

    // round count after reset
    localparam logic [RND_W-1:0] ROUND_COUNT_RST = 6'd32;

    typedef logic [3:0] t_nib;

    // s-boxes 0..7 for the round function, 8 and 9 for the key schedule
    localparam t_nib SBOX [10][16] = '{
        '{4'd14, 4'd9,  4'd15, 4'd0,  4'd13, 4'd4,  4'd10, 4'd11,
          4'd1,  4'd2,  4'd8,  4'd3,  4'd7,  4'd6,  4'd12, 4'd5},
        '{4'd4,  4'd11, 4'd14, 4'd9,  4'd15, 4'd13, 4'd0,  4'd10,
          4'd7,  4'd12, 4'd5,  4'd6,  4'd2,  4'd8,  4'd1,  4'd3},
        '{4'd1,  4'd14, 4'd7,  4'd12, 4'd15, 4'd13, 4'd0,  4'd6,
          4'd11, 4'd5,  4'd9,  4'd3,  4'd2,  4'd4,  4'd8,  4'd10},
        '{4'd7,  4'd6,  4'd8,  4'd11, 4'd0,  4'd15, 4'd3,  4'd14,
          4'd9,  4'd10, 4'd12, 4'd13, 4'd5,  4'd2,  4'd4,  4'd1},
        '{4'd14, 4'd5,  4'd15, 4'd0,  4'd7,  4'd2,  4'd12, 4'd13,
          4'd1,  4'd8,  4'd4,  4'd9,  4'd11, 4'd10, 4'd6,  4'd3},
        '{4'd2,  4'd13, 4'd11, 4'd12, 4'd15, 4'd14, 4'd0,  4'd9,
          4'd7,  4'd10, 4'd6,  4'd3,  4'd1,  4'd8,  4'd4,  4'd5},
        '{4'd11, 4'd9,  4'd4,  4'd14, 4'd0,  4'd15, 4'd10, 4'd13,
          4'd6,  4'd12, 4'd5,  4'd7,  4'd3,  4'd8,  4'd1,  4'd2},
        '{4'd13, 4'd10, 4'd15, 4'd0,  4'd14, 4'd4,  4'd9,  4'd11,
          4'd2,  4'd1,  4'd8,  4'd3,  4'd7,  4'd5,  4'd12, 4'd6},
        '{4'd8,  4'd7,  4'd14, 4'd5,  4'd15, 4'd13, 4'd0,  4'd6,
          4'd11, 4'd12, 4'd9,  4'd10, 4'd2,  4'd4,  4'd1,  4'd3},
        '{4'd11, 4'd5,  4'd15, 4'd0,  4'd7,  4'd2,  4'd9,  4'd13,
          4'd4,  4'd8,  4'd1,  4'd12, 4'd14, 4'd10, 4'd3,  4'd6}
    };

    // nibble permutation, counted from the top nibble
    localparam int PERM [8] = '{1, 3, 0, 2, 5, 7, 4, 6};

    // one data word moving through the cell row
    typedef struct packed {
        logic              valid;
        logic              action;
        logic [HALF_W-1:0] a;
        logic [HALF_W-1:0] b;
    } t_stage;

    // round key write broadcast from the key schedule to the cells
    typedef struct packed {
        logic              en;
        logic [KIDX_W-1:0] idx;
        logic [HALF_W-1:0] val;
    } t_key_wr;

    // f = p(s(x xor k))
    function automatic logic [HALF_W-1:0] f_round(input logic [HALF_W-1:0] x,
                                                  input logic [HALF_W-1:0] k);
        logic [HALF_W-1:0] y;
        logic [HALF_W-1:0] s;
        logic [HALF_W-1:0] p;
        y = x ^ k;
        for (int j = 0; j < 8; j++) begin
            s[31-4*j -: 4] = SBOX[7-j][y[31-4*j -: 4]];
        end
        for (int j = 0; j < 8; j++) begin
            p[31-4*j -: 4] = s[31-4*PERM[j] -: 4];
        end
        return p;
    endfunction

    // one key schedule step: rotate left 29, s-boxes on top byte, fold in counter
    function automatic logic [KEY_W-1:0] f_key_step(input logic [KEY_W-1:0]  k,
                                                    input logic [KIDX_W-1:0] i);
        logic [KEY_W-1:0] r;
        r          = {k[50:0], k[79:51]};
        r[79:76]   = SBOX[9][r[79:76]];
        r[75:72]   = SBOX[8][r[75:72]];
        r[50:46]   = r[50:46] ^ i;
        return r;
    endfunction

endpackage

// File: hw/rtl/lbc_key_sched.sv
// key schedule sequencer: one round key per cycle, broadcast to the cells
module lbc_key_sched #(
    parameter int MAX_ROUNDS = lbc_pkg::MAX_ROUNDS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_restart,
    input  logic [lbc_pkg::KEY_W-1:0] i_key,
    output lbc_pkg::t_key_wr         o_kw,
    output logic                     o_busy
);
    import lbc_pkg::*;

    localparam logic [KIDX_W-1:0] LAST_IDX = KIDX_W'(MAX_ROUNDS - 1);

    logic              r_busy;
    logic [KIDX_W-1:0] r_cnt;
    logic [KEY_W-1:0]  r_kreg;
    logic [KEY_W-1:0]  n_kreg;

    // first step loads the key, later steps advance the schedule
    always_comb begin
        if (r_cnt == '0) begin
            n_kreg = i_key;
        end else begin
            n_kreg = f_key_step(r_kreg, r_cnt);
        end
    end

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (i_restart) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (r_cnt == LAST_IDX) begin
                r_busy <= 1'b0;
                r_cnt  <= '0;
            end else begin
                r_cnt  <= r_cnt + 1'b1;
            end
        end
    end

    // key register
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_kreg <= n_kreg;
        end
    end

    assign o_kw.en  = r_busy;
    assign o_kw.idx = r_cnt;
    assign o_kw.val = n_kreg[KEY_W-1 -: HALF_W];
    assign o_busy   = r_busy;

    // round key writes only while the schedule runs
    a_kw_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_kw.en |-> o_busy)
        else $error("key write outside schedule run");

    // index advances by one per write until the last key
    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_restart && r_cnt != LAST_IDX) |=>
            (r_busy && r_cnt == $past(r_cnt) + 1'b1))
        else $error("key index did not advance");

    // a run ends right after the last key
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_restart && r_cnt == LAST_IDX) |=> !r_busy)
        else $error("schedule run did not end");

endmodule

// File: hw/rtl/lbc_round_cell.sv
// one feistel round cell: holds its two round keys and one pipeline stage
module lbc_round_cell #(
    parameter int MAX_ROUNDS = lbc_pkg::MAX_ROUNDS_DEF,
    parameter int STAGE      = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  lbc_pkg::t_key_wr          i_kw,
    input  logic [lbc_pkg::RND_W-1:0] i_rounds,
    input  lbc_pkg::t_stage           i_stage,
    output lbc_pkg::t_stage           o_stage
);
    import lbc_pkg::*;

    localparam logic [KIDX_W-1:0] ENC_IDX = KIDX_W'(STAGE);
    localparam logic [KIDX_W-1:0] DEC_IDX = KIDX_W'(MAX_ROUNDS - 1 - STAGE);
    localparam logic [RND_W-1:0]  STG     = RND_W'(STAGE);
    localparam logic [RND_W-1:0]  MAXR    = RND_W'(MAX_ROUNDS);

    logic [HALF_W-1:0] r_rk_enc;
    logic [HALF_W-1:0] r_rk_dec;
    logic              r_valid;
    logic              r_action;
    logic [HALF_W-1:0] r_a;
    logic [HALF_W-1:0] r_b;
    logic [HALF_W-1:0] n_a;
    logic [HALF_W-1:0] w_f;
    logic [HALF_W-1:0] w_t;
    logic              w_active;

    // capture this cell's round keys from the schedule broadcast
    always_ff @(posedge i_clk) begin
        if (i_kw.en && i_kw.idx == ENC_IDX) begin
            r_rk_enc <= i_kw.val;
        end
        if (i_kw.en && i_kw.idx == DEC_IDX) begin
            r_rk_dec <= i_kw.val;
        end
    end

    // encryption uses the first cells, decryption the last ones
    always_comb begin
        if (i_stage.action) begin
            w_active = (STG + i_rounds) >= MAXR;
            w_f      = f_round(i_stage.a, r_rk_dec);
        end else begin
            w_active = STG < i_rounds;
            w_f      = f_round(i_stage.a, r_rk_enc);
        end
        w_t = i_stage.b ^ w_f;
        if (i_stage.action) begin
            n_a = {w_t[7:0], w_t[31:8]};
        end else begin
            n_a = {i_stage.b[23:0], i_stage.b[31:24]} ^ w_f;
        end
    end

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_stage.valid;
        end
    end

    // stage payload, halves passed on unchanged when this cell is not one of the active rounds
    always_ff @(posedge i_clk) begin
        r_action <= i_stage.action;
        if (w_active) begin
            r_a <= n_a;
            r_b <= i_stage.a;
        end else begin
            r_a <= i_stage.a;
            r_b <= i_stage.b;
        end
    end

    assign o_stage.valid  = r_valid;
    assign o_stage.action = r_action;
    assign o_stage.a      = r_a;
    assign o_stage.b      = r_b;

endmodule

// File: hw/rtl/lblock_block_cipher.sv
// lblock 64/80 block cipher top level: config registers, key schedule, cell row
//
// Usage:
//   Configuration: write key_high (index 0), key_low (index 1) and
//   round_count (index 2) through i_cfg_we / i_cfg_idx / i_cfg_data, only
//   while no block is in flight. A key write restarts the key schedule;
//   busy is high while it runs.
//   Input: a block transfer happens at a clock edge with start high and
//   busy low; i_action selects encrypt (0) or decrypt (1).
//   Output: o_valid is high for one cycle with o_result_block.
//   The block passes the row of MAX_ROUNDS round cells, one round per cell;
//   cells outside the active rounds pass the block through.
//   Throughput is one block per cycle once busy is low.
//   Reset: registers return to the all-zero key and 32 rounds, the key
//   schedule runs with busy high, the row empties.
//   The receiver cannot stall: each result is shown for exactly one cycle.
module lblock_block_cipher #(
    parameter int MAX_ROUNDS = lbc_pkg::MAX_ROUNDS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lbc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lbc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_action,
    input  logic [lbc_pkg::BLOCK_W-1:0]    i_data_block,
    output logic                           o_valid,
    output logic [lbc_pkg::BLOCK_W-1:0]    o_result_block
);
    import lbc_pkg::*;

    logic [KEY_HIGH_W-1:0]  r_key_high;
    logic [BLOCK_W-1:0]     r_key_low;
    logic [RND_W-1:0]       r_round_count;
    logic                   w_restart;
    logic [RND_W-1:0]       w_rounds;
    logic                   w_busy;
    t_key_wr                w_kw;
    t_stage                 w_stage [MAX_ROUNDS+1];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high    <= '0;
            r_key_low     <= '0;
            r_round_count <= ROUND_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KEY_HIGH:    r_key_high    <= i_cfg_data[KEY_HIGH_W-1:0];
                CFG_KEY_LOW:     r_key_low     <= i_cfg_data;
                CFG_ROUND_COUNT: r_round_count <= i_cfg_data[RND_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // a key write restarts the schedule
    assign w_restart = i_cfg_we && (i_cfg_idx == CFG_KEY_HIGH || i_cfg_idx == CFG_KEY_LOW);

    // round count saturated to one .. MAX_ROUNDS
    always_comb begin
        if (r_round_count == '0) begin
            w_rounds = RND_W'(1);
        end else if (r_round_count > RND_W'(MAX_ROUNDS)) begin
            w_rounds = RND_W'(MAX_ROUNDS);
        end else begin
            w_rounds = r_round_count;
        end
    end

    lbc_key_sched #(
        .MAX_ROUNDS (MAX_ROUNDS)
    ) u_key_sched (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (w_restart),
        .i_key     ({r_key_high, r_key_low}),
        .o_kw      (w_kw),
        .o_busy    (w_busy)
    );

    // input transfer enters the first cell
    assign w_stage[0].valid  = start && !w_busy;
    assign w_stage[0].action = i_action;
    assign w_stage[0].a      = i_data_block[BLOCK_W-1 -: HALF_W];
    assign w_stage[0].b      = i_data_block[HALF_W-1:0];

    // row of round cells
    for (genvar g = 0; g < MAX_ROUNDS; g++) begin : g_cell
        lbc_round_cell #(
            .MAX_ROUNDS (MAX_ROUNDS),
            .STAGE      (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_kw     (w_kw),
            .i_rounds (w_rounds),
            .i_stage  (w_stage[g]),
            .o_stage  (w_stage[g+1])
        );
    end

    assign busy           = w_busy;
    assign o_valid        = w_stage[MAX_ROUNDS].valid;
    assign o_result_block = {w_stage[MAX_ROUNDS].b, w_stage[MAX_ROUNDS].a};

    // every accepted block comes out at the end of the cell row
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##MAX_ROUNDS o_valid)
        else $error("result missing after block transfer");

    // no result without a matching transfer
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##MAX_ROUNDS !o_valid)
        else $error("result without block transfer");

    // a key write always raises busy on the next cycle
    a_restart_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_restart |=> busy)
        else $error("key write did not start the schedule");

endmodule

// File: bench/lblock_cipher_checker.sv
`timescale 1ns / 1ps
// lblock cipher checker: tracks key setup, predicts each block result and compares it
module lblock_cipher_checker #(
    parameter int MAX_ROUNDS = lbc_pkg::MAX_ROUNDS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lbc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lbc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_start,
    input  logic                           i_busy,
    input  logic                           i_action,
    input  logic [lbc_pkg::BLOCK_W-1:0]    i_data_block,
    input  logic                           i_valid,
    input  logic [lbc_pkg::BLOCK_W-1:0]    i_result_block,
    output int                             o_pending,
    output int                             o_fail_count
);

    import lbc_pkg::*;

    // substitution tables, entry 0 in the top nibble of each row
    localparam logic [63:0] SUB_ROWS [10] = '{
        64'hE9F0_D4AB_1283_76C5,
        64'h4BE9_FD0A_7C56_2813,
        64'h1E7C_FD06_B593_248A,
        64'h768B_0F3E_9ACD_5241,
        64'hE5F0_72CD_1849_BA63,
        64'h2DBC_FE09_7A63_1845,
        64'hB94E_0FAD_6C57_3812,
        64'hDAF0_E49B_2183_75C6,
        64'h87E5_FD06_BC9A_2413,
        64'hB5F0_729D_481C_EA36
    };

    // output nibble j takes substituted nibble NIB_ORDER[j], counted from the top
    localparam int NIB_ORDER [8] = '{1, 3, 0, 2, 5, 7, 4, 6};

    logic [KEY_HIGH_W-1:0] key_high_q;
    logic [63:0]           key_low_q;
    logic [RND_W-1:0]      round_count_q;
    logic [HALF_W-1:0]     round_keys [MAX_ROUNDS];
    logic [BLOCK_W-1:0]    expected_blocks [$];
    logic [BLOCK_W-1:0]    want_block;
    int                    fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic logic [3:0] sub_nibble(input int row, input logic [3:0] v);
        int pos;
        pos = 63 - 4 * int'(v);
        return SUB_ROWS[row][pos -: 4];
    endfunction

    // f = p(s(x xor k))
    function automatic logic [HALF_W-1:0] mix_half(input logic [HALF_W-1:0] x,
                                                   input logic [HALF_W-1:0] k);
        logic [HALF_W-1:0] y;
        logic [HALF_W-1:0] s;
        logic [HALF_W-1:0] p;
        int                j;
        y = x ^ k;
        for (j = 0; j < 8; j++) begin
            s[31-4*j -: 4] = sub_nibble(7 - j, y[31-4*j -: 4]);
        end
        for (j = 0; j < 8; j++) begin
            p[31-4*j -: 4] = s[31-4*NIB_ORDER[j] -: 4];
        end
        return p;
    endfunction

    // round key expansion from the current key registers
    function automatic void expand_round_keys();
        logic [KEY_W-1:0] k;
        int               i;
        k = {key_high_q, key_low_q};
        round_keys[0] = k[79:48];
        for (i = 1; i < MAX_ROUNDS; i++) begin
            k          = {k[50:0], k[79:51]};
            k[79:76]   = sub_nibble(9, k[79:76]);
            k[75:72]   = sub_nibble(8, k[75:72]);
            k[50:46]   = k[50:46] ^ 5'(i);
            round_keys[i] = k[79:48];
        end
    endfunction

    // round count saturated to 1..MAX_ROUNDS
    function automatic int rounds_in_use();
        int r;
        r = int'(round_count_q);
        if (r < 1) r = 1;
        if (r > MAX_ROUNDS) r = MAX_ROUNDS;
        return r;
    endfunction

    function automatic logic [BLOCK_W-1:0] cipher_block(input logic act,
                                                        input logic [BLOCK_W-1:0] blk);
        logic [HALF_W-1:0] lh;
        logic [HALF_W-1:0] rh;
        logic [HALF_W-1:0] t;
        int                n;
        int                i;
        n = rounds_in_use();
        if (!act) begin
            lh = blk[63:32];
            rh = blk[31:0];
            for (i = 0; i < n; i++) begin
                t  = {rh[23:0], rh[31:24]} ^ mix_half(lh, round_keys[i]);
                rh = lh;
                lh = t;
            end
            return {rh, lh};
        end else begin
            rh = blk[63:32];
            lh = blk[31:0];
            for (i = n; i > 0; i--) begin
                t  = lh ^ mix_half(rh, round_keys[i-1]);
                lh = rh;
                rh = {t[7:0], t[31:8]};
            end
            return {lh, rh};
        end
    endfunction

    // watch config writes, block transfers and result transfers
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_high_q    = '0;
            key_low_q     = '0;
            round_count_q = ROUND_COUNT_RST;
            expand_round_keys();
            expected_blocks.delete();
            o_pending <= 0;
        end else begin
            // result transfer against the oldest prediction
            if (i_valid === 1'b1) begin
                if (expected_blocks.size() == 0) begin
                    $error("result_block: nothing expected, actual %h", i_result_block);
                    fail_count++;
                end else begin
                    want_block = expected_blocks.pop_front();
                    if (i_result_block !== want_block) begin
                        $error("result_block: expected %h, actual %h",
                               want_block, i_result_block);
                        fail_count++;
                    end
                end
            end
            // register write, unknown index ignored
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_KEY_HIGH: begin
                        key_high_q = i_cfg_data[KEY_HIGH_W-1:0];
                        expand_round_keys();
                    end
                    CFG_KEY_LOW: begin
                        key_low_q = i_cfg_data[63:0];
                        expand_round_keys();
                    end
                    CFG_ROUND_COUNT: begin
                        round_count_q = i_cfg_data[RND_W-1:0];
                        expand_round_keys();
                    end
                    default: ;
                endcase
            end
            // block transfer
            if (i_start && !i_busy) begin
                expected_blocks.push_back(cipher_block(i_action, i_data_block));
            end
            o_pending <= expected_blocks.size();
        end
    end

endmodule

// File: bench/tb_lblock_block_cipher.sv
`timescale 1ns / 1ps
// testbench top for the lblock cipher: clock, reset, stimulus and verdict
module tb_lblock_block_cipher;

    import lbc_pkg::*;

    localparam int MAX_ROUNDS    = MAX_ROUNDS_DEF;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_BLOCKS = 1100;
    localparam int QUIET_TAIL    = 150;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;
    logic                  start        = 1'b0;
    logic                  busy;
    logic                  i_action     = 1'b0;
    logic [BLOCK_W-1:0]    i_data_block = '0;
    logic                  o_valid;
    logic [BLOCK_W-1:0]    o_result_block;
    int                    pending;
    int                    fail_count;
    int                    cycle_count  = 0;

    lblock_block_cipher #(
        .MAX_ROUNDS (MAX_ROUNDS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_data_block   (i_data_block),
        .o_valid        (o_valid),
        .o_result_block (o_result_block)
    );

    lblock_cipher_checker #(
        .MAX_ROUNDS (MAX_ROUNDS)
    ) i_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_start        (start),
        .i_busy         (busy),
        .i_action       (i_action),
        .i_data_block   (i_data_block),
        .i_valid        (o_valid),
        .i_result_block (o_result_block),
        .o_pending      (pending),
        .o_fail_count   (fail_count)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // mostly random blocks, now and then an extreme or a single set bit
    function automatic logic [63:0] pick_block();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            2:       return 64'd1 << $urandom_range(0, 63);
            default: return rand64();
        endcase
    endfunction

    // round count value, saturating cases included
    function automatic logic [63:0] pick_round_count();
        logic [63:0] v;
        v = rand64();
        case ($urandom_range(0, 7))
            0:       v[RND_W-1:0] = 6'd0;
            1:       v[RND_W-1:0] = 6'($urandom_range(33, 63));
            2:       v[RND_W-1:0] = 6'd1;
            3:       v[RND_W-1:0] = 6'd32;
            default: v[RND_W-1:0] = 6'($urandom_range(1, 32));
        endcase
        return v;
    endfunction

    // one block transfer, start held until busy is low at an edge
    task automatic send_block(input logic act, input logic [63:0] blk);
        start        <= 1'b1;
        i_action     <= act;
        i_data_block <= blk;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic pause(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // stop sending and wait for every predicted result
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    // close a group of writes and let the key schedule finish
    task automatic end_writes();
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // random key setup between phases
    task automatic random_setup();
        int pick;
        drain();
        pick = $urandom_range(0, 9);
        if (pick != 0) write_reg(CFG_KEY_HIGH, rand64());
        if (pick != 1) write_reg(CFG_KEY_LOW, rand64());
        if (pick == 2) write_reg(CFG_UNUSED, rand64());
        write_reg(CFG_ROUND_COUNT, pick_round_count());
        end_writes();
    endtask

    initial begin
        int  random_sent;
        int  n;
        int  k;
        logic gaps_on;

        random_sent = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);

        // all-zero key and full rounds after reset
        send_block(1'b0, 64'h0);
        send_block(1'b0, '1);
        send_block(1'b1, 64'h0);
        send_block(1'b1, '1);
        send_block(1'b0, 64'hAAAA_AAAA_AAAA_AAAA);
        send_block(1'b1, 64'h5555_5555_5555_5555);

        // all-ones key, zero round count runs a single round
        drain();
        write_reg(CFG_KEY_HIGH, '1);
        write_reg(CFG_KEY_LOW, '1);
        write_reg(CFG_ROUND_COUNT, 64'h0);
        end_writes();
        send_block(1'b0, 64'h0123_4567_89AB_CDEF);
        send_block(1'b1, 64'h0123_4567_89AB_CDEF);
        send_block(1'b0, '1);

        // round count above the maximum saturates, unused index changes nothing
        drain();
        write_reg(CFG_ROUND_COUNT, '1);
        write_reg(CFG_UNUSED, '1);
        end_writes();
        send_block(1'b0, 64'h0);
        send_block(1'b1, 64'hFEDC_BA98_7654_3210);
        send_block(1'b0, 64'h8000_0000_0000_0001);

        // just above the maximum, with a sparse key
        drain();
        write_reg(CFG_KEY_HIGH, 64'h0);
        write_reg(CFG_KEY_LOW, 64'h8000_0000_0000_0001);
        write_reg(CFG_ROUND_COUNT, 64'd33);
        end_writes();
        send_block(1'b0, 64'h0);
        send_block(1'b1, 64'h0);

        // one round, then one short of the maximum
        drain();
        write_reg(CFG_ROUND_COUNT, 64'd1);
        end_writes();
        send_block(1'b0, '1);
        send_block(1'b1, '1);
        drain();
        write_reg(CFG_ROUND_COUNT, 64'd31);
        end_writes();
        send_block(1'b0, 64'h0000_0001_0000_0000);
        send_block(1'b1, 64'h0000_0000_8000_0000);

        // random phases, each with its own key and round count
        while (random_sent < RANDOM_BLOCKS) begin
            random_setup();
            gaps_on = ($urandom_range(0, 2) != 0);
            n = $urandom_range(20, 120);
            if (RANDOM_BLOCKS - random_sent - n < QUIET_TAIL) n = RANDOM_BLOCKS - random_sent;
            for (k = 0; k < n; k++) begin
                if (gaps_on && random_sent < RANDOM_BLOCKS - QUIET_TAIL
                    && $urandom_range(0, 3) == 0) begin
                    pause($urandom_range(1, 5));
                end
                send_block(1'($urandom_range(0, 1)), pick_block());
                random_sent++;
            end
        end

        // drain and watch for stray results
        drain();
        repeat (MAX_ROUNDS + 8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
